// ===== design/crpp_pkg.sv =====
// Shared types, codes and constants of the camera reply packet parser.
// No dependencies; used by the other parser modules and the testbench.
`default_nettype none

package crpp_pkg;

  // Longest packet before an oversize report.
  localparam int MAX_PACKET_BYTES = 16;
  localparam int HEAD_DEPTH       = 6;
  localparam int COUNT_W          = 5;
  localparam int HEAD_IDX_W       = 3;
  localparam int CAM_W            = 3;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 1;

  localparam logic [COUNT_W-1:0] MAX_LEN  = COUNT_W'(MAX_PACKET_BYTES);
  localparam logic [COUNT_W-1:0] HEAD_LEN = COUNT_W'(HEAD_DEPTH);

  // Byte values and masks of the reply protocol
  localparam logic [7:0] BYTE_TERM      = 8'hFF;
  localparam logic [3:0] NIB_COMPLETE   = 4'h5;
  localparam logic [3:0] NIB_ACK        = 4'h4;
  localparam logic [3:0] NIB_DEV_ERROR  = 4'h6;
  localparam logic [7:0] IR_TAG_1       = 8'h07;
  localparam logic [7:0] IR_TAG_2       = 8'h7D;
  localparam logic [7:0] IR_TAG_3       = 8'h02;
  localparam logic [7:0] CHAIN_TAG      = 8'h38;
  localparam logic [7:0] BCAST_ADDR     = 8'h88;
  localparam logic [7:0] COUNT_TAG      = 8'h30;
  localparam logic [7:0] CAM_ADDR_BASE  = 8'h08;
  localparam logic [7:0] MAX_CAMERAS    = 8'h07;

  // Packet lengths that the classifier checks
  localparam logic [COUNT_W-1:0] LEN_SHORT = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] LEN_ERROR = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] LEN_IR    = COUNT_W'(7);

  typedef enum logic [1:0] {
    EV_BYTE       = 2'd0,
    EV_TIMEOUT    = 2'd1,
    EV_LINK_ERROR = 2'd2
  } link_event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPRESS_ACK = 2'd0,
    CFG_REPORT_IR    = 2'd1,
    CFG_REPORT_CHAIN = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_COMPLETE   = 4'd0,
    ST_ACK        = 4'd1,
    ST_IR         = 4'd2,
    ST_CHAIN      = 4'd3,
    ST_UNDERSIZED = 4'd4,
    ST_DEV_ERROR  = 4'd5,
    ST_COUNT      = 4'd6,
    ST_BROADCAST  = 4'd7,
    ST_UNKNOWN    = 4'd8,
    ST_OVERSIZED  = 4'd9,
    ST_TIMEOUT    = 4'd10,
    ST_LINK_ERROR = 4'd11
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [1:0] link_event;
  } item_t;

  typedef struct packed {
    logic suppress_ack;
    logic report_ir;
    logic report_chain;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       error_code;
    logic [7:0]       source_camera;
    logic [7:0]       ir_first_byte;
    logic [7:0]       ir_second_byte;
    logic [CAM_W-1:0] cameras_in_chain;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } step_t;

endpackage

`default_nettype wire

// ===== design/crpp_in_if.sv =====
// Input channel of the camera reply packet parser: valid/ready plus one byte or link event.
// Depends on nothing.
`default_nettype none

interface crpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [1:0] link_event;

  modport source (output valid, rx_byte, link_event, input ready);
  modport sink   (input valid, rx_byte, link_event, output ready);
endinterface

`default_nettype wire

// ===== design/crpp_out_if.sv =====
// Result channel of the camera reply packet parser: valid/ready plus one reply report.
// Depends on nothing.
`default_nettype none

interface crpp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [7:0] error_code;
  logic [7:0] source_camera;
  logic [7:0] ir_first_byte;
  logic [7:0] ir_second_byte;
  logic [2:0] cameras_in_chain;

  modport source (output valid, status, error_code, source_camera, ir_first_byte,
                  ir_second_byte, cameras_in_chain, input ready);
  modport sink   (input valid, status, error_code, source_camera, ir_first_byte,
                  ir_second_byte, cameras_in_chain, output ready);
endinterface

`default_nettype wire

// ===== design/crpp_in_stage.sv =====
// Input register of the parser: holds one accepted transaction until the assembler takes it.
// Depends on crpp_pkg and crpp_in_if.
`default_nettype none

module crpp_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  crpp_in_if.sink            rx,
  input  wire logic          advance,
  output logic               item_valid,
  output crpp_pkg::item_t    item
);

  logic take;

  assign rx.ready = !item_valid || advance;
  assign take     = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.rx_byte    <= rx.rx_byte;
      item.link_event <= rx.link_event;
    end
  end

endmodule

`default_nettype wire

// ===== design/crpp_assembler.sv =====
// Packet assembly state and reply classification, one transaction per cycle
// while fire is high. Depends on crpp_pkg.
`default_nettype none

module crpp_assembler (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire crpp_pkg::item_t  item,
  input  wire crpp_pkg::cfg_t   cfg,
  output crpp_pkg::step_t       step
);

  logic [crpp_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic [crpp_pkg::CAM_W-1:0]   camera_total, camera_total_next;
  logic [7:0]                   head_bytes [crpp_pkg::HEAD_DEPTH];

  logic [7:0]                   h [crpp_pkg::HEAD_DEPTH];
  logic [crpp_pkg::COUNT_W-1:0] len;
  logic [7:0]                   cam;
  logic [7:0]                   n;
  logic                         head_we;

  // Current byte overrides the stored one at its slot (terminator bypass)
  always_comb begin
    for (int i = 0; i < crpp_pkg::HEAD_DEPTH; i++) begin
      h[i] = (byte_count == crpp_pkg::COUNT_W'(i)) ? item.rx_byte : head_bytes[i];
    end
  end

  assign len     = byte_count + crpp_pkg::COUNT_W'(1);
  assign cam     = {4'h0, h[0][7:4]} - crpp_pkg::CAM_ADDR_BASE;
  assign n       = h[2] - 8'd1;
  assign head_we = fire && (item.link_event == crpp_pkg::EV_BYTE)
                   && (byte_count < crpp_pkg::HEAD_LEN);

  always_comb begin
    byte_count_next   = byte_count;
    camera_total_next = camera_total;
    step              = '0;
    case (crpp_pkg::link_event_t'(item.link_event))
      crpp_pkg::EV_BYTE: begin
        if (item.rx_byte == crpp_pkg::BYTE_TERM) begin
          byte_count_next = '0;
          if (len >= crpp_pkg::LEN_SHORT && h[1][7:4] == crpp_pkg::NIB_COMPLETE) begin
            step.emit       = 1'b1;
            step.res.status = crpp_pkg::ST_COMPLETE;
          end else if (len == crpp_pkg::LEN_SHORT && h[1][7:4] == crpp_pkg::NIB_ACK) begin
            step.emit       = !cfg.suppress_ack;
            step.res.status = crpp_pkg::ST_ACK;
          end else if (len == crpp_pkg::LEN_IR && h[1] == crpp_pkg::IR_TAG_1
                       && h[2] == crpp_pkg::IR_TAG_2 && h[3] == crpp_pkg::IR_TAG_3) begin
            step.emit               = cfg.report_ir;
            step.res.status         = crpp_pkg::ST_IR;
            step.res.source_camera  = cam;
            step.res.ir_first_byte  = h[4];
            step.res.ir_second_byte = h[5];
          end else if (len == crpp_pkg::LEN_SHORT && h[1] == crpp_pkg::CHAIN_TAG) begin
            step.emit              = cfg.report_chain;
            step.res.status        = crpp_pkg::ST_CHAIN;
            step.res.source_camera = cam;
          end else if (len < crpp_pkg::LEN_SHORT) begin
            step.emit       = 1'b1;
            step.res.status = crpp_pkg::ST_UNDERSIZED;
          end else if (len == crpp_pkg::LEN_ERROR && h[1][7:4] == crpp_pkg::NIB_DEV_ERROR) begin
            step.emit           = 1'b1;
            step.res.status     = crpp_pkg::ST_DEV_ERROR;
            step.res.error_code = h[2];
          end else if (len == crpp_pkg::LEN_ERROR && h[0] == crpp_pkg::BCAST_ADDR
                       && h[1] == crpp_pkg::COUNT_TAG) begin
            step.emit = 1'b1;
            if (n == 8'd0 || n > crpp_pkg::MAX_CAMERAS) begin
              step.res.status = crpp_pkg::ST_UNKNOWN;
            end else begin
              step.res.status   = crpp_pkg::ST_COUNT;
              camera_total_next = n[crpp_pkg::CAM_W-1:0];
            end
          end else if (h[0] == crpp_pkg::BCAST_ADDR) begin
            step.emit       = 1'b1;
            step.res.status = crpp_pkg::ST_BROADCAST;
          end else begin
            step.emit       = 1'b1;
            step.res.status = crpp_pkg::ST_UNKNOWN;
          end
        end else if (len >= crpp_pkg::MAX_LEN) begin
          byte_count_next = '0;
          step.emit       = 1'b1;
          step.res.status = crpp_pkg::ST_OVERSIZED;
        end else begin
          byte_count_next = len;
        end
      end
      crpp_pkg::EV_TIMEOUT: begin
        byte_count_next = '0;
        step.emit       = 1'b1;
        step.res.status = crpp_pkg::ST_TIMEOUT;
      end
      default: begin
        // link read error, and the unused event code
        byte_count_next = '0;
        step.emit       = 1'b1;
        step.res.status = crpp_pkg::ST_LINK_ERROR;
      end
    endcase
    step.res.cameras_in_chain = camera_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      camera_total <= '0;
    end else if (fire) begin
      byte_count   <= byte_count_next;
      camera_total <= camera_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_bytes[byte_count[crpp_pkg::HEAD_IDX_W-1:0]] <= item.rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== design/crpp_out_stage.sv =====
// Result register of the parser: holds one report until the downstream side takes it.
// Depends on crpp_pkg and crpp_out_if.
`default_nettype none

module crpp_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire crpp_pkg::step_t  step,
  output logic                  can_take,
  crpp_out_if.source            tx
);

  logic              valid;
  crpp_pkg::result_t res;
  logic              load;

  assign can_take = !valid || tx.ready;
  assign load     = fire && step.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (tx.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= step.res;
    end
  end

  assign tx.valid            = valid;
  assign tx.status           = res.status;
  assign tx.error_code       = res.error_code;
  assign tx.source_camera    = res.source_camera;
  assign tx.ir_first_byte    = res.ir_first_byte;
  assign tx.ir_second_byte   = res.ir_second_byte;
  assign tx.cameras_in_chain = res.cameras_in_chain;

endmodule

`default_nettype wire

// ===== design/camera_reply_packet_parser.sv =====
// Camera reply packet parser, top level: config registers, input register, assembler, result reg.
// Depends on crpp_pkg, crpp_in_if, crpp_out_if, crpp_in_stage, crpp_assembler, crpp_out_stage.
//
// Takes one transaction per cycle on rx: a received reply byte (link_event 0) or a link
// timeout / read error. Bytes are counted and the first six kept; 0xFF ends a packet,
// which is sorted into completion, ack, IR push, chain change, undersized, device
// error, camera count, broadcast or unknown. A packet that reaches 16 bytes without a
// terminator is reported oversized; link events and oversize drop the packet in
// progress. Each transaction gives at most one report on tx. Throughput is one
// transaction per clock, set by the single assembler stage that reads and updates the
// packet state, until backpressure on tx fills both registers; a report passes through
// the input register, which holds its transaction while the assembler works, and then
// the result register before it is valid on tx. Backpressure on tx stalls rx only once
// both registers are full. Configuration (cfg_write/cfg_index/cfg_data) should be
// written only while the parser is idle; writes to unused indexes are dropped.
`default_nettype none

module camera_reply_packet_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  crpp_in_if.sink                             rx,
  crpp_out_if.source                          tx,
  input  wire logic                           cfg_write,
  input  wire logic [crpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crpp_pkg::CFG_DATA_W-1:0] cfg_data
);

  crpp_pkg::cfg_t  cfg;
  crpp_pkg::item_t item;
  crpp_pkg::step_t step;
  logic            item_valid;
  logic            can_take;
  logic            fire;

  // Config registers; reset: ack reported, IR and chain reports on
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.suppress_ack <= 1'b0;
      cfg.report_ir    <= 1'b1;
      cfg.report_chain <= 1'b1;
    end else if (cfg_write) begin
      case (crpp_pkg::cfg_index_t'(cfg_index))
        crpp_pkg::CFG_SUPPRESS_ACK: cfg.suppress_ack <= cfg_data[0];
        crpp_pkg::CFG_REPORT_IR:    cfg.report_ir    <= cfg_data[0];
        crpp_pkg::CFG_REPORT_CHAIN: cfg.report_chain <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The held transaction is processed once the result register can take its report
  assign fire = item_valid && can_take;

  crpp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .advance    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  crpp_assembler u_asm (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .cfg  (cfg),
    .step (step)
  );

  crpp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .step     (step),
    .can_take (can_take),
    .tx       (tx)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for camera_reply_packet_parser: directed and random reply streams,
// register settings, random idling on both channels. Depends on crpp_pkg, crpp_in_if,
// crpp_out_if and the parser RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb;

  typedef logic [7:0] byte_q_t[$];

  // Event code the parser has no name for; it must behave as a link read error.
  localparam logic [1:0] EV_UNUSED = 2'd3;
  // Hard stop: far beyond the slowest legal run.
  localparam int RUN_LIMIT_NS = 4_000_000;
  // Input register plus result register, with margin.
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_PRINTED = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic [crpp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [crpp_pkg::CFG_DATA_W-1:0] cfg_data;

  crpp_in_if  rx_if ();
  crpp_out_if tx_if ();

  camera_reply_packet_parser uut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_if.sink),
    .tx        (tx_if.source),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Reply predictor: own copy of the packet assembly state and the registers.
  // ---------------------------------------------------------------------------
  int                 pkt_len;
  logic [7:0]         pkt_head [crpp_pkg::HEAD_DEPTH];
  logic [2:0]         camera_total;
  crpp_pkg::cfg_t     parser_cfg;
  crpp_pkg::result_t  replies_due[$];

  int  mismatches = 0;
  int  items_sent = 0;
  bit  gaps_on    = 1'b1;

  // Works out the report (if any) for one accepted transaction and queues it.
  function automatic void predict_reply(logic [7:0] b, logic [1:0] ev);
    crpp_pkg::result_t r;
    int                len;
    logic [7:0]        n;
    bit                give;
    r    = '0;
    give = 1'b1;
    if (ev == crpp_pkg::EV_TIMEOUT) begin
      pkt_len  = 0;
      r.status = crpp_pkg::ST_TIMEOUT;
    end else if (ev != crpp_pkg::EV_BYTE) begin
      // read error and the unused code both drop the packet as a link error
      pkt_len  = 0;
      r.status = crpp_pkg::ST_LINK_ERROR;
    end else begin
      if (pkt_len < crpp_pkg::HEAD_DEPTH) pkt_head[pkt_len] = b;
      len = pkt_len + 1;
      if (b == crpp_pkg::BYTE_TERM) begin
        pkt_len = 0;
        // priority order matters: first match wins
        if (len >= crpp_pkg::LEN_SHORT && pkt_head[1][7:4] == crpp_pkg::NIB_COMPLETE) begin
          r.status = crpp_pkg::ST_COMPLETE;
        end else if (len == crpp_pkg::LEN_SHORT &&
                     pkt_head[1][7:4] == crpp_pkg::NIB_ACK) begin
          r.status = crpp_pkg::ST_ACK;
          give     = !parser_cfg.suppress_ack;
        end else if (len == crpp_pkg::LEN_IR && pkt_head[1] == crpp_pkg::IR_TAG_1 &&
                     pkt_head[2] == crpp_pkg::IR_TAG_2 &&
                     pkt_head[3] == crpp_pkg::IR_TAG_3) begin
          r.status         = crpp_pkg::ST_IR;
          r.source_camera  = {4'h0, pkt_head[0][7:4]} - crpp_pkg::CAM_ADDR_BASE;
          r.ir_first_byte  = pkt_head[4];
          r.ir_second_byte = pkt_head[5];
          give             = parser_cfg.report_ir;
        end else if (len == crpp_pkg::LEN_SHORT && pkt_head[1] == crpp_pkg::CHAIN_TAG) begin
          r.status        = crpp_pkg::ST_CHAIN;
          r.source_camera = {4'h0, pkt_head[0][7:4]} - crpp_pkg::CAM_ADDR_BASE;
          give            = parser_cfg.report_chain;
        end else if (len < crpp_pkg::LEN_SHORT) begin
          r.status = crpp_pkg::ST_UNDERSIZED;
        end else if (len == crpp_pkg::LEN_ERROR &&
                     pkt_head[1][7:4] == crpp_pkg::NIB_DEV_ERROR) begin
          r.status     = crpp_pkg::ST_DEV_ERROR;
          r.error_code = pkt_head[2];
        end else if (len == crpp_pkg::LEN_ERROR && pkt_head[0] == crpp_pkg::BCAST_ADDR &&
                     pkt_head[1] == crpp_pkg::COUNT_TAG) begin
          // count byte is one above the camera total; only 1..7 is stored
          n = pkt_head[2] - 8'd1;
          if (n == 8'd0 || n > crpp_pkg::MAX_CAMERAS) begin
            r.status = crpp_pkg::ST_UNKNOWN;
          end else begin
            camera_total = n[2:0];
            r.status     = crpp_pkg::ST_COUNT;
          end
        end else if (pkt_head[0] == crpp_pkg::BCAST_ADDR) begin
          r.status = crpp_pkg::ST_BROADCAST;
        end else begin
          r.status = crpp_pkg::ST_UNKNOWN;
        end
      end else if (len >= crpp_pkg::MAX_PACKET_BYTES) begin
        pkt_len  = 0;
        r.status = crpp_pkg::ST_OVERSIZED;
      end else begin
        pkt_len = len;
        give    = 1'b0;
      end
    end
    r.cameras_in_chain = camera_total;
    if (give) replies_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: every tx transaction against the oldest queued report.
  // Sampled at the falling edge, where both channels are stable until the next
  // rising edge, so a handshake seen here is the one taken at that edge.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(negedge clk) begin
    crpp_pkg::result_t want;
    if (!rst && tx_if.valid === 1'b1 && tx_if.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        report_mismatch("report with none pending, status", 8'(tx_if.status), 8'h0);
      end else begin
        want = replies_due.pop_front();
        if (tx_if.status !== want.status)
          report_mismatch("status", 8'(tx_if.status), 8'(want.status));
        if (tx_if.error_code !== want.error_code)
          report_mismatch("error_code", tx_if.error_code, want.error_code);
        if (tx_if.source_camera !== want.source_camera)
          report_mismatch("source_camera", tx_if.source_camera, want.source_camera);
        if (tx_if.ir_first_byte !== want.ir_first_byte)
          report_mismatch("ir_first_byte", tx_if.ir_first_byte, want.ir_first_byte);
        if (tx_if.ir_second_byte !== want.ir_second_byte)
          report_mismatch("ir_second_byte", tx_if.ir_second_byte, want.ir_second_byte);
        if (tx_if.cameras_in_chain !== want.cameras_in_chain)
          report_mismatch("cameras_in_chain", 8'(tx_if.cameras_in_chain),
                          8'(want.cameras_in_chain));
      end
    end
  end

  // Result side stalls ~15% of cycles unless gaps are switched off.
  always @(posedge clk) begin
    tx_if.ready <= !gaps_on || ($urandom_range(99) >= 15);
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // One rx transaction. valid is left high on return; the next call or an
  // idle phase lowers it, so valid never sees two updates in one time step.
  task automatic send_item(logic [7:0] b, logic [1:0] ev);
    bit taken;
    while (gaps_on && $urandom_range(99) < 15) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid      <= 1'b1;
    rx_if.rx_byte    <= b;
    rx_if.link_event <= ev;
    do begin
      @(negedge clk);
      taken = (rx_if.ready === 1'b1);
      @(posedge clk);
    end while (!taken);
    predict_reply(b, ev);
    items_sent++;
  endtask

  task automatic send_packet(byte_q_t pkt);
    foreach (pkt[i]) send_item(pkt[i], crpp_pkg::EV_BYTE);
  endtask

  function automatic logic [7:0] body_byte();
    return 8'($urandom_range(0, 254));  // anything but the terminator
  endfunction

  function automatic logic [3:0] any_nibble();
    return 4'($urandom_range(0, 15));
  endfunction

  // Mostly well-formed replies of every kind with random content; the rest are
  // corrupted, cut off by link events, overlong, or plain noise.
  task automatic send_random_packet();
    byte_q_t pkt;
    int      kind;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // completion, possibly with trailing bytes
      pkt.push_back(body_byte());
      pkt.push_back({crpp_pkg::NIB_COMPLETE, any_nibble()});
      repeat ($urandom_range(0, 6)) pkt.push_back(body_byte());
    end else if (kind < 20) begin
      pkt.push_back(body_byte());
      pkt.push_back({crpp_pkg::NIB_ACK, any_nibble()});
    end else if (kind < 32) begin
      pkt.push_back(body_byte());
      pkt.push_back(crpp_pkg::IR_TAG_1);
      pkt.push_back(crpp_pkg::IR_TAG_2);
      pkt.push_back(crpp_pkg::IR_TAG_3);
      pkt.push_back(body_byte());
      pkt.push_back(body_byte());
      if ($urandom_range(3) == 0) pkt[$urandom_range(1, 3)] = body_byte();
    end else if (kind < 42) begin
      pkt.push_back(body_byte());
      pkt.push_back(crpp_pkg::CHAIN_TAG);
    end else if (kind < 48) begin
      repeat ($urandom_range(0, 1)) pkt.push_back(body_byte());
    end else if (kind < 56) begin
      pkt.push_back(body_byte());
      pkt.push_back({crpp_pkg::NIB_DEV_ERROR, any_nibble()});
      pkt.push_back(body_byte());
    end else if (kind < 66) begin
      // camera count: small values hit the range edges, some are wild
      pkt.push_back(crpp_pkg::BCAST_ADDR);
      pkt.push_back(crpp_pkg::COUNT_TAG);
      pkt.push_back(($urandom_range(3) == 0) ? body_byte() : 8'($urandom_range(0, 9)));
    end else if (kind < 72) begin
      pkt.push_back(crpp_pkg::BCAST_ADDR);
      repeat ($urandom_range(1, 8)) pkt.push_back(body_byte());
    end else if (kind < 80) begin
      repeat ($urandom_range(1, crpp_pkg::MAX_PACKET_BYTES - 1)) pkt.push_back(body_byte());
    end else if (kind < 86) begin
      // no terminator: oversize, leftover bytes open the next packet
      repeat ($urandom_range(crpp_pkg::MAX_PACKET_BYTES, crpp_pkg::MAX_PACKET_BYTES + 2))
        pkt.push_back(body_byte());
      send_packet(pkt);
      return;
    end else if (kind < 93) begin
      // packet cut off by a link event (any of the three non-byte codes)
      repeat ($urandom_range(0, 8)) pkt.push_back(body_byte());
      send_packet(pkt);
      send_item(8'($urandom_range(0, 255)), 2'($urandom_range(1, 3)));
      return;
    end else begin
      repeat ($urandom_range(1, 4))
        send_item(($urandom_range(3) == 0) ? crpp_pkg::BYTE_TERM : 8'($urandom_range(0, 255)),
                  2'($urandom_range(0, 3)));
      return;
    end
    pkt.push_back(crpp_pkg::BYTE_TERM);
    send_packet(pkt);
  endtask

  // Drop valid and wait for every queued report, then let the pipeline empty:
  // suppressed or silent transactions can still be in flight at that point.
  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back; only called with the parser idle.
  task automatic apply_settings(crpp_pkg::cfg_t s);
    crpp_pkg::cfg_index_t idx;
    wait_idle();
    idx = idx.first();
    repeat (3) begin
      cfg_write <= 1'b1;
      cfg_index <= idx;
      case (idx)
        crpp_pkg::CFG_SUPPRESS_ACK: cfg_data <= s.suppress_ack;
        crpp_pkg::CFG_REPORT_IR:    cfg_data <= s.report_ir;
        default:                    cfg_data <= s.report_chain;
      endcase
      @(posedge clk);
      idx = idx.next();
    end
    cfg_write  <= 1'b0;
    parser_cfg = s;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Undersized, completion, ack, IR, chain, device error and count replies at reset settings, then the link events.
  task automatic test_reply_kinds();
    byte_q_t pkt;
    pkt.push_back(crpp_pkg::BYTE_TERM);                       // lone terminator
    pkt.push_back(8'h90); pkt.push_back(8'h50); pkt.push_back(crpp_pkg::BYTE_TERM);
    pkt.push_back(8'h90); pkt.push_back(8'h41); pkt.push_back(crpp_pkg::BYTE_TERM);
    // IR push from camera 0 with key bytes
    pkt.push_back(8'h80); pkt.push_back(crpp_pkg::IR_TAG_1); pkt.push_back(crpp_pkg::IR_TAG_2);
    pkt.push_back(crpp_pkg::IR_TAG_3); pkt.push_back(8'h12); pkt.push_back(8'hED);
    pkt.push_back(crpp_pkg::BYTE_TERM);
    // chain change with address nibble 0: camera number wraps
    pkt.push_back(8'h00); pkt.push_back(crpp_pkg::CHAIN_TAG); pkt.push_back(crpp_pkg::BYTE_TERM);
    pkt.push_back(8'h90); pkt.push_back(8'h60); pkt.push_back(8'h41);
    pkt.push_back(crpp_pkg::BYTE_TERM);
    // count of seven cameras, the top of the stored range
    pkt.push_back(crpp_pkg::BCAST_ADDR); pkt.push_back(crpp_pkg::COUNT_TAG);
    pkt.push_back(8'h08); pkt.push_back(crpp_pkg::BYTE_TERM);
    pkt.push_back(8'h90);
    send_packet(pkt);
    send_item(8'hFF, crpp_pkg::EV_TIMEOUT);       // abandons the open packet
    send_item(8'h00, crpp_pkg::EV_LINK_ERROR);
    send_item(8'hA5, EV_UNUSED);
  endtask

  // Every combination of the three registers, all-off and all-on included.
  task automatic test_register_settings();
    for (int s = 0; s < 8; s++) begin
      apply_settings(crpp_pkg::cfg_t'(s));
      repeat (12) send_random_packet();
    end
  endtask

  // Sender holds off until every report is back, then resumes.
  task automatic test_drain_pause();
    repeat (6) send_random_packet();
    wait_idle();
    repeat (6) send_random_packet();
  endtask

  // Bulk random traffic in phases with random settings; one phase has no gaps.
  task automatic test_random_traffic();
    int goal;
    for (int phase = 0; phase < 4; phase++) begin
      apply_settings(crpp_pkg::cfg_t'($urandom_range(0, 7)));
      gaps_on = (phase != 2);
      goal    = items_sent + 250;
      while (items_sent < goal) send_random_packet();
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int guard;
    rx_if.valid      = 1'b0;
    rx_if.rx_byte    = 8'h00;
    rx_if.link_event = crpp_pkg::EV_BYTE;
    tx_if.ready      = 1'b0;
    cfg_write        = 1'b0;
    cfg_index        = crpp_pkg::CFG_SUPPRESS_ACK;
    cfg_data         = '0;
    // predictor reset state; head bytes are cleared before use
    pkt_len      = 0;
    camera_total = '0;
    foreach (pkt_head[i]) pkt_head[i] = 8'h00;
    parser_cfg.suppress_ack = 1'b0;
    parser_cfg.report_ir    = 1'b1;
    parser_cfg.report_chain = 1'b1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reply_kinds();
    test_register_settings();
    test_drain_pause();
    test_random_traffic();

    // drain with a bound, then give stray reports a chance to show up
    rx_if.valid <= 1'b0;
    guard = 0;
    while (replies_due.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (replies_due.size() != 0)
      report_mismatch("reports never delivered", 8'(replies_due.size()), 8'h0);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
